// ----- hw/rtl/kss_pkg.sv -----
`timescale 1ns / 1ps
package kss_pkg;

    localparam int unsigned POS_W = 10;
    localparam int unsigned VAL_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_MID,
        ST_RD_HI,
        ST_SW_MID,
        ST_SW_HI,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_RD,
        ST_FIN_WA,
        ST_FIN_WB,
        ST_RD_K,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        RA_MID,
        RA_HI,
        RA_I,
        RA_DST,
        RA_K
    } t_raddr;

    typedef enum logic [2:0] {
        WA_IDX,
        WA_MID,
        WA_HI,
        WA_I,
        WA_DST
    } t_waddr;

    typedef enum logic [1:0] {
        WD_VAL,
        WD_RDATA,
        WD_PIV,
        WD_CUR
    } t_wdata;

    typedef struct packed {
        logic   load_sel;
        logic   wr_en;
        t_waddr wa;
        t_wdata wd;
        t_raddr ra;
        logic   cap_piv;
        logic   cap_cur;
        logic   init_scan;
        logic   adv_i;
        logic   adv_dst;
        logic   narrow;
        logic   load_out;
    } t_cmd;

    typedef struct packed {
        logic gt;
        logic less;
        logic same;
        logic last;
        logic hit;
        logic idx_ok;
    } t_stat;

endpackage

// ----- hw/rtl/kss_ram.sv -----
`timescale 1ns / 1ps
module kss_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/kss_dp.sv -----
`timescale 1ns / 1ps
module kss_dp #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          i_clk,
    input  kss_pkg::t_cmd                 i_cmd,
    output kss_pkg::t_stat                o_stat,
    input  logic [kss_pkg::POS_W-1:0]     i_index,
    input  logic signed [kss_pkg::VAL_W-1:0] i_value,
    input  logic [kss_pkg::POS_W-1:0]     i_range_low,
    input  logic [kss_pkg::POS_W-1:0]     i_range_high,
    input  logic [kss_pkg::POS_W-1:0]     i_rank,
    output logic signed [kss_pkg::VAL_W-1:0] o_selected
);
    import kss_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = (AW > POS_W) ? AW : POS_W;
    localparam logic [CW-1:0] LAST_POS = CW'(DEPTH - 1);

    logic [AW-1:0]    r_lo, r_hi, r_k, r_i, r_dst;
    logic [VAL_W-1:0] r_piv, r_cur, r_sel;
    logic [AW-1:0]    n_lo, n_hi;
    logic [AW-1:0]    w_mid, w_raddr, w_waddr;
    logic [VAL_W-1:0] w_wdata, w_rdata;
    logic [AW:0]      w_sum;
    logic [CW-1:0]    w_low_x, w_high_x, w_rank_x, w_idx_x;

    assign w_low_x  = CW'(i_range_low);
    assign w_high_x = CW'(i_range_high);
    assign w_rank_x = CW'(i_rank);
    assign w_idx_x  = CW'(i_index);

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[AW:1];

    always_comb begin
        n_lo = (w_low_x > LAST_POS) ? AW'(LAST_POS) : AW'(w_low_x);
        n_hi = (w_high_x > LAST_POS) ? AW'(LAST_POS) : AW'(w_high_x);
        if (i_cmd.narrow) begin
            n_lo = r_lo;
            n_hi = r_hi;
            if (r_dst > r_k) begin
                n_hi = r_dst - AW'(1);
            end else if (r_dst < r_k) begin
                n_lo = r_dst + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sel || i_cmd.narrow) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_cmd.load_sel) begin
            r_k <= (w_rank_x > LAST_POS) ? AW'(LAST_POS) : AW'(w_rank_x);
        end
        if (i_cmd.init_scan) begin
            r_i   <= r_lo;
            r_dst <= r_lo;
        end else begin
            if (i_cmd.adv_i) begin
                r_i <= r_i + AW'(1);
            end
            if (i_cmd.adv_dst) begin
                r_dst <= r_dst + AW'(1);
            end
        end
        if (i_cmd.cap_piv) begin
            r_piv <= w_rdata;
        end
        if (i_cmd.cap_cur) begin
            r_cur <= w_rdata;
        end
        if (i_cmd.load_out) begin
            r_sel <= w_rdata;
        end
    end

    always_comb begin
        case (i_cmd.ra)
            RA_MID:  w_raddr = w_mid;
            RA_HI:   w_raddr = r_hi;
            RA_I:    w_raddr = r_i;
            RA_DST:  w_raddr = r_dst;
            RA_K:    w_raddr = r_k;
            default: w_raddr = r_k;
        endcase
    end

    always_comb begin
        case (i_cmd.wa)
            WA_IDX:  w_waddr = AW'(w_idx_x);
            WA_MID:  w_waddr = w_mid;
            WA_HI:   w_waddr = r_hi;
            WA_I:    w_waddr = r_i;
            WA_DST:  w_waddr = r_dst;
            default: w_waddr = r_dst;
        endcase
    end

    always_comb begin
        case (i_cmd.wd)
            WD_VAL:   w_wdata = i_value;
            WD_RDATA: w_wdata = w_rdata;
            WD_PIV:   w_wdata = r_piv;
            WD_CUR:   w_wdata = r_cur;
            default:  w_wdata = r_cur;
        endcase
    end

    kss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stat.gt     = r_hi > r_lo;
    assign o_stat.less   = $signed(w_rdata) < $signed(r_piv);
    assign o_stat.same   = r_dst == r_i;
    assign o_stat.last   = ({1'b0, r_i} + (AW + 1)'(1)) == {1'b0, r_hi};
    assign o_stat.hit    = r_dst == r_k;
    assign o_stat.idx_ok = w_idx_x <= LAST_POS;

    assign o_selected = r_sel;

`ifndef SYNTH
    a_scan_in_bounds: assert property (@(posedge i_clk)
        i_cmd.adv_i |-> (r_i < r_hi) && (r_i >= r_lo))
        else $error("scan index left the partition bounds");

    a_dst_behind_scan: assert property (@(posedge i_clk)
        i_cmd.adv_i |-> r_dst <= r_i)
        else $error("store point ran ahead of scan index");

    a_pivot_held: assert property (@(posedge i_clk)
        i_cmd.adv_i |=> $stable(r_piv))
        else $error("pivot changed during scan");
`endif

endmodule

// ----- hw/rtl/kss_ctrl.sv -----
`timescale 1ns / 1ps
module kss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_op,
    output logic           o_valid,
    input  logic           i_ready,
    input  kss_pkg::t_stat i_stat,
    output kss_pkg::t_cmd  o_cmd
);
    import kss_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid;
    logic   w_accept, w_slot_free;

    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (w_accept && i_op) n_state = ST_CHECK;
            ST_CHECK:    n_state = i_stat.gt ? ST_RD_MID : ST_RD_K;
            ST_RD_MID:   n_state = ST_RD_HI;
            ST_RD_HI:    n_state = ST_SW_MID;
            ST_SW_MID:   n_state = ST_SW_HI;
            ST_SW_HI:    n_state = ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (i_stat.less && !i_stat.same) begin
                    n_state = ST_SWAP_A;
                end else begin
                    n_state = i_stat.last ? ST_FIN_RD : ST_SCAN_RD;
                end
            end
            ST_SWAP_A:   n_state = ST_SWAP_B;
            ST_SWAP_B:   n_state = i_stat.last ? ST_FIN_RD : ST_SCAN_RD;
            ST_FIN_RD:   n_state = ST_FIN_WA;
            ST_FIN_WA:   n_state = ST_FIN_WB;
            ST_FIN_WB:   n_state = i_stat.hit ? ST_RD_K : ST_CHECK;
            ST_RD_K:     n_state = ST_OUT;
            ST_OUT:      if (w_slot_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{
            load_sel:  1'b0,
            wr_en:     1'b0,
            wa:        WA_IDX,
            wd:        WD_VAL,
            ra:        RA_K,
            cap_piv:   1'b0,
            cap_cur:   1'b0,
            init_scan: 1'b0,
            adv_i:     1'b0,
            adv_dst:   1'b0,
            narrow:    1'b0,
            load_out:  1'b0
        };
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_sel = w_accept && i_op;
                o_cmd.wr_en    = w_accept && !i_op && i_stat.idx_ok;
            end
            ST_RD_MID: begin
                o_cmd.ra = RA_MID;
            end
            ST_RD_HI: begin
                o_cmd.ra      = RA_HI;
                o_cmd.cap_piv = 1'b1;
            end
            ST_SW_MID: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wa    = WA_MID;
                o_cmd.wd    = WD_RDATA;
            end
            ST_SW_HI: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wa        = WA_HI;
                o_cmd.wd        = WD_PIV;
                o_cmd.init_scan = 1'b1;
            end
            ST_SCAN_RD: begin
                o_cmd.ra = RA_I;
            end
            ST_SCAN_CMP: begin
                o_cmd.ra      = RA_DST;
                o_cmd.cap_cur = 1'b1;
                if (!i_stat.less) begin
                    o_cmd.adv_i = 1'b1;
                end else if (i_stat.same) begin
                    o_cmd.adv_i   = 1'b1;
                    o_cmd.adv_dst = 1'b1;
                end
            end
            ST_SWAP_A: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wa    = WA_I;
                o_cmd.wd    = WD_RDATA;
            end
            ST_SWAP_B: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wa      = WA_DST;
                o_cmd.wd      = WD_CUR;
                o_cmd.adv_i   = 1'b1;
                o_cmd.adv_dst = 1'b1;
            end
            ST_FIN_RD: begin
                o_cmd.ra = RA_DST;
            end
            ST_FIN_WA: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wa    = WA_HI;
                o_cmd.wd    = WD_RDATA;
            end
            ST_FIN_WB: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa     = WA_DST;
                o_cmd.wd     = WD_PIV;
                o_cmd.narrow = 1'b1;
            end
            ST_RD_K: begin
                o_cmd.ra = RA_K;
            end
            ST_OUT: begin
                o_cmd.ra       = RA_K;
                o_cmd.load_out = w_slot_free;
            end
            default: begin
                o_cmd.ra = RA_K;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;

`ifndef SYNTH
    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> w_slot_free)
        else $error("result beat overwritten before it was taken");

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_OUT))
        else $error("result beat raised outside the result state");

    a_select_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op) |=> r_state == ST_CHECK)
        else $error("accepted select did not start");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_op) |=> r_state == ST_IDLE)
        else $error("write beat left idle");
`endif

endmodule

// ----- hw/rtl/kth_smallest_select_core.sv -----
`timescale 1ns / 1ps
// Quickselect engine over a DEPTH-entry store of signed 32-bit elements.
// A write beat (op = 0) stores one element; indexes at
// or above DEPTH are dropped. A select beat (op = 1) runs Lomuto partition
// passes with the middle element as pivot over the clamped bounds, leaves
// the store reordered, and returns the element at the rank position. The
// store is one RAM with a single read port and registered read data, so a
// pass reads the middle and high entries, moves the pivot to the high end,
// then reads and compares each scanned element, swapping it with the store
// point when it is below the pivot and the store point lags the scan, and
// last places the pivot at the store point; the worst case is quadratic.
// One item is in flight at a time; the result sits in an output register.
// Entries must be written before a select reads them; there is no
// clearing pass after reset.
module kth_smallest_select_core #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [kss_pkg::POS_W-1:0]            i_index,
    input  logic signed [kss_pkg::VAL_W-1:0]     i_value,
    input  logic [kss_pkg::POS_W-1:0]            i_range_low,
    input  logic [kss_pkg::POS_W-1:0]            i_range_high,
    input  logic [kss_pkg::POS_W-1:0]            i_rank,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [kss_pkg::VAL_W-1:0]     o_selected
);
    import kss_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    kss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    kss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_rank       (i_rank),
        .o_selected   (o_selected)
    );

endmodule

// ----- tb/kth_smallest_select_core_test.sv -----
`timescale 1ns / 1ps
module kth_smallest_select_core_test;
    import kss_pkg::*;

    localparam int unsigned DEPTH           = 1024;
    localparam logic        OP_WRITE        = 1'b0;
    localparam logic        OP_SELECT       = 1'b1;
    localparam int unsigned RAND_BEATS      = 115;
    localparam int unsigned WATCHDOG_LIMIT  = 40000;
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned HOLD_OFF_AFTER  = 15;
    localparam int unsigned DIRECTED_ROWS   = 23;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                    op;
        logic [POS_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        lo;
        logic [POS_W-1:0]        hi;
        logic [POS_W-1:0]        rank;
        logic                    pinned;
        logic signed [VAL_W-1:0] pinned_val;
    } t_sel_beat;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PULSE
    } t_rx_mode;

    localparam t_sel_beat DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{OP_WRITE,  10'd0,    VAL_MAX, 10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd1,    VAL_MIN, 10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd2,    32'sd0,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd3,    -32'sd1, 10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd4,    32'sd7,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd5,    -32'sd7, 10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd6,    32'sd7,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd7,    32'sd1,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd1023, VAL_MIN, 10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd512,  VAL_MAX, 10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd1023, 10'd1023, 10'd1023, 1'b1, VAL_MIN},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd512,  10'd512,  10'd512,  1'b1, VAL_MAX},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd5,    10'd2,    10'd0,    1'b1, VAL_MAX},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd0,    10'd7,    10'd0,    1'b1, VAL_MIN},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd0,    10'd7,    10'd7,    1'b1, VAL_MAX},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd0,    10'd7,    10'd3,    1'b0, 32'sd0},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd2,    10'd6,    10'd0,    1'b0, 32'sd0},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd0,    10'd4,    10'd7,    1'b0, 32'sd0},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd0,    10'd7,    10'd4,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd8,    32'sd9,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd9,    32'sd9,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_WRITE,  10'd10,   32'sd9,  10'd0,    10'd0,    10'd0,    1'b0, 32'sd0},
        '{OP_SELECT, 10'd0,    32'sd0,  10'd8,    10'd10,   10'd9,    1'b1, 32'sd9}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_op;
    logic [POS_W-1:0]        i_index;
    logic signed [VAL_W-1:0] i_value;
    logic [POS_W-1:0]        i_range_low;
    logic [POS_W-1:0]        i_range_high;
    logic [POS_W-1:0]        i_rank;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [VAL_W-1:0] o_selected;

    logic signed [VAL_W-1:0] store_model [DEPTH];
    bit                      filled [DEPTH];
    int                      filled_pos [$];
    t_sel_beat               offered_q [$];
    logic signed [VAL_W-1:0] selected_q [$];

    int err_count    = 0;
    int writes_seen  = 0;
    int selects_seen = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int widest_range = 0;
    int rand_beats   = 0;
    int burst_left   = 0;
    bit held_off     = 1'b0;

    kth_smallest_select_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .i_rank      (i_rank),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_selected  (o_selected)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void swap_model(int a, int b);
        logic signed [VAL_W-1:0] t;
        t              = store_model[a];
        store_model[a] = store_model[b];
        store_model[b] = t;
    endfunction

    function automatic int lomuto_pass(int lo, int hi);
        int                      mid;
        int                      dst;
        logic signed [VAL_W-1:0] piv;
        mid = (lo + hi) / 2;
        piv = store_model[mid];
        dst = lo;
        swap_model(mid, hi);
        for (int i = lo; i < hi; i++) begin
            if (store_model[i] < piv) begin
                swap_model(dst, i);
                dst++;
            end
        end
        swap_model(dst, hi);
        return dst;
    endfunction

    function automatic logic signed [VAL_W-1:0] select_model(int lo, int hi, int k);
        int p;
        while (hi > lo) begin
            p = lomuto_pass(lo, hi);
            if (p > k) begin
                hi = p - 1;
            end else if (p < k) begin
                lo = p + 1;
            end else begin
                break;
            end
        end
        return store_model[k];
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_filled();
        return filled_pos[$urandom_range(0, filled_pos.size() - 1)];
    endfunction

    task automatic push_beat(t_sel_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        if (b.op == OP_WRITE && !filled[b.index]) begin
            filled[b.index] = 1'b1;
            filled_pos.push_back(int'(b.index));
        end
        offered_q.push_back(b);
        i_valid      <= 1'b1;
        i_op         <= b.op;
        i_index      <= b.index;
        i_value      <= b.value;
        i_range_low  <= b.lo;
        i_range_high <= b.hi;
        i_rank       <= b.rank;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic offer_write(int pos, logic signed [VAL_W-1:0] v);
        t_sel_beat b;
        b       = '0;
        b.op    = OP_WRITE;
        b.index = POS_W'(pos);
        b.value = v;
        b.lo    = POS_W'($urandom);
        b.hi    = POS_W'($urandom);
        b.rank  = POS_W'($urandom);
        rand_beats++;
        push_beat(b);
    endtask

    task automatic offer_select(int lo, int hi, int rk);
        t_sel_beat b;
        b       = '0;
        b.op    = OP_SELECT;
        b.index = POS_W'($urandom);
        b.value = $urandom;
        b.lo    = POS_W'(lo);
        b.hi    = POS_W'(hi);
        b.rank  = POS_W'(rk);
        rand_beats++;
        push_beat(b);
    endtask

    always @(posedge i_clk) begin : monitor
        t_sel_beat               b;
        logic signed [VAL_W-1:0] want;
        bit                      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && i_ready) begin
                moved = 1'b1;
                results_seen++;
                if (selected_q.size() == 0) begin
                    $error("selected: expected none, actual %0d", o_selected);
                    err_count++;
                end else begin
                    want = selected_q.pop_front();
                    if (o_selected !== want) begin
                        $error("selected: expected %0d, actual %0d", want, o_selected);
                        err_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                moved = 1'b1;
                b     = offered_q.pop_front();
                if (b.op == OP_WRITE) begin
                    store_model[b.index] = b.value;
                    writes_seen++;
                end else begin
                    want = select_model(int'(b.lo), int'(b.hi), int'(b.rank));
                    if (b.pinned) begin
                        want = b.pinned_val;
                    end
                    selected_q.push_back(want);
                    selects_seen++;
                    if (b.hi > b.lo && int'(b.hi - b.lo) + 1 > widest_range) begin
                        widest_range = int'(b.hi - b.lo) + 1;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("kth_smallest_select_core: mismatch");
                $finish;
            end
        end
    end

    initial begin : receiver
        t_rx_mode mode;
        int       span;
        int       phase;
        i_ready = 1'b0;
        phase   = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 40);
            repeat (span) begin
                @(negedge i_clk);
                if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
                    held_off = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                end
                phase++;
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int w;
        int room;
        int base;
        int lo;
        int hi;
        int rk;
        int t;
        bit flat;
        logic signed [VAL_W-1:0] flat_val;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_WRITE;
        i_index      = '0;
        i_value      = '0;
        i_range_low  = '0;
        i_range_high = '0;
        i_rank       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            push_beat(DIRECTED_PLAN[r]);
        end

        while (rand_beats < RAND_BEATS) begin
            w        = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 64)
                                                    : $urandom_range(2, 12);
            room     = int'(RAND_BEATS) - rand_beats;
            if (w > room) begin
                w = (room < 2) ? 2 : room;
            end
            base     = $urandom_range(0, DEPTH - w);
            flat     = ($urandom_range(0, 5) == 0);
            flat_val = rand_elem();
            for (int j = 0; j < w; j++) begin
                offer_write(base + j, flat ? flat_val : rand_elem());
            end
            repeat ($urandom_range(2, 4)) begin
                lo = base + $urandom_range(0, w - 1);
                hi = base + $urandom_range(0, w - 1);
                if (lo > hi && $urandom_range(0, 3) != 0) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                if ($urandom_range(0, 4) == 0) begin
                    rk = pick_filled();
                end else if (lo <= hi) begin
                    rk = $urandom_range(lo, hi);
                end else begin
                    rk = $urandom_range(hi, lo);
                end
                offer_select(lo, hi, rk);
            end
            case ($urandom_range(0, 2))
                0: offer_write($urandom_range(0, DEPTH - 1), rand_elem());
                1: begin
                    lo = $urandom_range(0, DEPTH - 1);
                    offer_select(lo, $urandom_range(0, lo), pick_filled());
                end
                default: ;
            endcase
        end
        i_valid <= 1'b0;

        while (selected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (selected_q.size() != 0) begin
            $error("selected: %0d expected results never arrived", selected_q.size());
            err_count++;
        end

        $display("run: %0d write beats, %0d select beats, %0d results checked",
                 writes_seen, selects_seen, results_seen);
        $display("run: widest partitioned range %0d, receiver hold-off %0d cycles",
                 widest_range, held_off ? HOLD_OFF_CYCLES : 0);
        if (err_count == 0) begin
            $display("kth_smallest_select_core: match");
        end else begin
            $display("kth_smallest_select_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/kss_pkg.sv
hw/rtl/kss_ram.sv
hw/rtl/kss_dp.sv
hw/rtl/kss_ctrl.sv
hw/rtl/kth_smallest_select_core.sv
tb/kth_smallest_select_core_test.sv
